### src/mfne_pkg.sv
// ---------------------------------------------------------------------------
// mfne_pkg
// Shared types, constants and helper functions of the MIDI note extractor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfne_pkg;

  localparam int MAX_NOTES_DEF      = 512;
  localparam int MAX_FILE_BYTES_DEF = 65536;

  localparam logic [23:0] DEFAULT_TEMPO_RST = 24'd500000;
  localparam logic [15:0] FALLBACK_TPQ_RST  = 16'd480;
  localparam logic [9:0]  MS_DIVISOR        = 10'd1000;

  localparam int          ADDR_W            = 3;
  localparam logic        REG_DEFAULT_TEMPO = 1'b0;
  localparam logic        REG_FALLBACK_TPQ  = 1'b1;

  localparam logic        KIND_NOTE = 1'b0;
  localparam logic        KIND_END  = 1'b1;

  localparam logic [1:0]  ST_OK        = 2'd0;
  localparam logic [1:0]  ST_SHORT     = 2'd1;
  localparam logic [1:0]  ST_BAD_MAGIC = 2'd2;
  localparam logic [1:0]  ST_BAD_TRACK = 2'd3;

  localparam logic [7:0]  EV_META     = 8'hFF;
  localparam logic [7:0]  EV_SYSEX    = 8'hF0;
  localparam logic [7:0]  EV_SYSEX_C  = 8'hF7;
  localparam logic [7:0]  META_TEMPO  = 8'h51;
  localparam logic [3:0]  HI_NOTE_ON  = 4'h9;
  localparam logic [3:0]  HI_NOTE_OFF = 4'h8;
  localparam logic [3:0]  HI_POLY_AT  = 4'hA;
  localparam logic [3:0]  HI_CTRL     = 4'hB;
  localparam logic [3:0]  HI_BEND     = 4'hE;

  localparam int PROD_W = 56;
  localparam int DIV_W  = 26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  note;
    logic [31:0] duration_ms;
    logic [9:0]  note_count;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic step;
    logic mul0;
    logic mul1;
    logic div;
    logic load_note;
    logic load_end;
  } dp_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] file_magic(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h4D;
      2'd1: r = 8'h54;
      2'd2: r = 8'h68;
      default: r = 8'h64;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] track_magic(input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = 8'h4D;
      2'd1: r = 8'h54;
      2'd2: r = 8'h72;
      default: r = 8'h6B;
    endcase
    return r;
  endfunction

endpackage

### src/mfne_ctrl.sv
// ---------------------------------------------------------------------------
// mfne_ctrl
// Sequencer: takes bytes, runs the duration multiply-divide, issues results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfne_ctrl
  import mfne_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL0 = 6'b000010,
    S_MUL1 = 6'b000100,
    S_DIV  = 6'b001000,
    S_NOTE = 6'b010000,
    S_END  = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic        end_pend, end_pend_next;

  always_comb begin
    state_next    = state;
    end_pend_next = end_pend;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step      = 1'b1;
          end_pend_next = in_last;
          if (stat.emit) state_next = S_MUL0;
          else if (in_last) state_next = S_END;
        end
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_done) state_next = S_NOTE;
      end
      S_NOTE: begin
        if (stat.out_free) begin
          cmd.load_note = 1'b1;
          state_next    = end_pend ? S_END : S_IDLE;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.load_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      end_pend <= 1'b0;
    end else begin
      state    <= state_next;
      end_pend <= end_pend_next;
    end
  end

endmodule

### src/mfne_datapath.sv
// ---------------------------------------------------------------------------
// mfne_datapath
// Parse state, note start memory, multiply-divide unit and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfne_datapath
  import mfne_pkg::*;
#(
  parameter int MAX_NOTES      = MAX_NOTES_DEF,
  parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF
)(
  input  logic        clk,
  input  logic        rst,
  input  in_word_t    in_word,
  input  logic [23:0] default_tempo_us,
  input  logic [15:0] fallback_ticks_per_quarter,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output out_word_t   out_word,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int NW = $clog2(MAX_NOTES + 1);
  localparam int PW = $clog2(MAX_FILE_BYTES + 1);
  localparam int CW = $clog2(PROD_W);

  typedef enum logic [12:0] {
    PH_FILE_HDR   = 13'b0000000000001,
    PH_TRK_HDR    = 13'b0000000000010,
    PH_DELTA      = 13'b0000000000100,
    PH_STATUS     = 13'b0000000001000,
    PH_META_TYPE  = 13'b0000000010000,
    PH_META_LEN   = 13'b0000000100000,
    PH_META_DATA  = 13'b0000001000000,
    PH_SYSEX_LEN  = 13'b0000010000000,
    PH_SKIP       = 13'b0000100000000,
    PH_KEY        = 13'b0001000000000,
    PH_VEL        = 13'b0010000000000,
    PH_SKIP_TRACK = 13'b0100000000000,
    PH_DONE       = 13'b1000000000000
  } phase_t;

  phase_t        phase, phase_n;
  logic [PW-1:0] pos, pos_n;
  logic [15:0]   div, div_n, tt, tt_n, td, td_n;
  logic [31:0]   tbl, tbl_n, tick, tick_n;
  logic [7:0]    rs, rs_n, evc, evc_n, mk, mk_n;
  logic [23:0]   tempo, tempo_n, tg, tg_n;
  logic [27:0]   vacc, vacc_n, skip, skip_n;
  logic [1:0]    vcnt, vcnt_n, midx, midx_n, pst, pst_n;
  logic [6:0]    held, held_n;
  logic [127:0]  active, active_n;
  logic [NW-1:0] notes, notes_n;
  logic [3:0]    hidx, hidx_n;
  logic          hbad, hbad_n, take, take_n;
  logic          emit, wr_en;

  logic [31:0]   mem [128];
  logic [31:0]   start_q;

  logic [6:0]    snap_note;
  logic [9:0]    snap_count;
  logic [31:0]   snap_tick;
  logic [23:0]   snap_tempo;
  logic [15:0]   snap_tpq;
  logic [9:0]    end_count;
  logic [1:0]    end_status;

  logic [PROD_W-1:0] q;
  logic [DIV_W-1:0]  dvs, rem;
  logic [CW-1:0]     cnt;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  ev;
    logic [27:0] fed;
    logic        vdone;
    logic        body;
    logic        ntd;
    b        = in_word.data_byte;
    ev       = '0;
    fed      = '0;
    vdone    = 1'b0;
    body     = 1'b0;
    ntd      = 1'b0;
    phase_n  = phase;   pos_n  = pos;   div_n  = div;   tt_n   = tt;   td_n  = td;
    tbl_n    = tbl;     tick_n = tick;  rs_n   = rs;    evc_n  = evc;  mk_n  = mk;
    tempo_n  = tempo;   tg_n   = tg;    vacc_n = vacc;  skip_n = skip; vcnt_n = vcnt;
    midx_n   = midx;    pst_n  = pst;   held_n = held;  active_n = active;
    notes_n  = notes;   hidx_n = hidx;  hbad_n = hbad;  take_n = take;
    emit     = 1'b0;
    wr_en    = 1'b0;

    if (pos < PW'(MAX_FILE_BYTES)) begin
      pos_n = pos + 1'b1;
      unique case (phase)
        PH_FILE_HDR: begin
          if (pos == '0) tempo_n = default_tempo_us;
          if (pos < PW'(4) && b != file_magic(pos[1:0])) begin
            pst_n   = ST_BAD_MAGIC;
            phase_n = PH_DONE;
          end else if (pos == PW'(10)) tt_n = {b, 8'h00};
          else if (pos == PW'(11)) tt_n = {tt[15:8], b};
          else if (pos == PW'(12)) div_n = {b, 8'h00};
          else if (pos == PW'(13)) begin
            div_n = {div[15:8], b};
            ntd   = 1'b1;
          end
        end
        PH_TRK_HDR: begin
          if (hidx < 4'd4) begin
            if (b != track_magic(hidx[1:0])) hbad_n = 1'b1;
          end else tbl_n = {tbl[23:0], b};
          hidx_n = hidx + 1'b1;
          if (hidx_n == 4'd8) begin
            if (hbad_n) begin
              pst_n   = ST_BAD_TRACK;
              phase_n = PH_DONE;
            end else begin
              active_n = '0;
              tick_n   = '0;
              rs_n     = '0;
              if (tbl_n == '0) begin
                td_n = td + 1'b1;
                ntd  = 1'b1;
              end else if (notes >= NW'(MAX_NOTES)) phase_n = PH_SKIP_TRACK;
              else begin
                vacc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
              end
            end
          end
        end
        PH_DONE: ;
        default: begin
          tbl_n = tbl - 1'b1;
          if (phase == PH_DELTA) begin
            fed    = {vacc[20:0], b[6:0]};
            vacc_n = fed;
            if (!b[7] || vcnt == 2'd3) begin
              tick_n  = tick + {4'b0, fed};
              phase_n = PH_STATUS;
            end else vcnt_n = vcnt + 1'b1;
          end else if (phase == PH_STATUS) begin
            if (b[7]) begin
              rs_n = b;
              ev   = b;
            end else ev = rs;
            evc_n = ev;
            body  = !b[7];
            if (ev == EV_META) phase_n = PH_META_TYPE;
            else if (ev == EV_SYSEX || ev == EV_SYSEX_C) begin
              vacc_n = '0; vcnt_n = '0; phase_n = PH_SYSEX_LEN;
            end else if (ev[7:4] == HI_NOTE_ON || ev[7:4] == HI_NOTE_OFF) phase_n = PH_KEY;
            else if (ev[7:4] == HI_POLY_AT || ev[7:4] == HI_CTRL || ev[7:4] == HI_BEND) begin
              skip_n = 28'd2; phase_n = PH_SKIP;
            end else begin
              skip_n = 28'd1; phase_n = PH_SKIP;
            end
          end else if (phase != PH_SKIP_TRACK) body = 1'b1;

          if (body) begin
            fed   = {vacc_n[20:0], b[6:0]};
            vdone = !b[7] || vcnt_n == 2'd3;
            unique case (phase_n)
              PH_META_TYPE: begin
                mk_n = b; vacc_n = '0; vcnt_n = '0; phase_n = PH_META_LEN;
              end
              PH_META_LEN: begin
                if (vdone) begin
                  if ({4'b0, fed} > tbl_n) phase_n = PH_SKIP_TRACK;
                  else if (fed == '0) begin
                    vacc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
                  end else begin
                    skip_n  = fed;
                    take_n  = (mk == META_TEMPO) && (fed >= 28'd3);
                    midx_n  = '0;
                    tg_n    = '0;
                    phase_n = PH_META_DATA;
                  end
                end else begin
                  vacc_n = fed; vcnt_n = vcnt_n + 1'b1;
                end
              end
              PH_META_DATA: begin
                if (take && midx != 2'd3) begin
                  tg_n = {tg[15:0], b};
                  if (midx == 2'd2) tempo_n = {tg[15:0], b};
                end
                if (midx != 2'd3) midx_n = midx + 1'b1;
                skip_n = skip - 1'b1;
                if (skip_n == '0) begin
                  vacc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
                end
              end
              PH_SYSEX_LEN: begin
                if (vdone) begin
                  if (fed == '0) begin
                    vacc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
                  end else begin
                    skip_n = fed; phase_n = PH_SKIP;
                  end
                end else begin
                  vacc_n = fed; vcnt_n = vcnt_n + 1'b1;
                end
              end
              PH_SKIP: begin
                if (skip_n <= 28'd1) begin
                  skip_n = '0; vacc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
                end else skip_n = skip_n - 1'b1;
              end
              PH_KEY: begin
                held_n  = b[6:0];
                phase_n = PH_VEL;
              end
              PH_VEL: begin
                if (evc_n[7:4] == HI_NOTE_ON && b != 8'h00) begin
                  wr_en          = 1'b1;
                  active_n[held] = 1'b1;
                end else if (active[held]) begin
                  if (notes < NW'(MAX_NOTES)) begin
                    emit    = 1'b1;
                    notes_n = notes + 1'b1;
                  end
                  active_n[held] = 1'b0;
                end
                if (notes_n >= NW'(MAX_NOTES)) phase_n = PH_SKIP_TRACK;
                else begin
                  vacc_n = '0; vcnt_n = '0; phase_n = PH_DELTA;
                end
              end
              default: ;
            endcase
          end
          if (tbl_n == '0) begin
            td_n = td + 1'b1;
            ntd  = 1'b1;
          end
        end
      endcase
      if (ntd) begin
        if (td_n >= tt) phase_n = PH_DONE;
        else begin
          phase_n = PH_TRK_HDR; hidx_n = '0; hbad_n = 1'b0; tbl_n = '0;
        end
      end
    end
  end

  // Parse state; the final byte of a file puts everything back to its start values.
  always_ff @(posedge clk) begin
    if (rst || (cmd.step && in_word.last_byte)) begin
      phase  <= PH_FILE_HDR;
      pos    <= '0;  div  <= '0;  tt   <= '0;  td   <= '0;  tbl  <= '0;
      tick   <= '0;  rs   <= '0;  evc  <= '0;  mk   <= '0;  tg   <= '0;
      vacc   <= '0;  skip <= '0;  vcnt <= '0;  midx <= '0;  pst  <= '0;
      held   <= '0;  active <= '0; notes <= '0; hidx <= '0; hbad <= 1'b0;
      take   <= 1'b0;
      tempo  <= rst ? DEFAULT_TEMPO_RST : default_tempo_us;
    end else if (cmd.step) begin
      phase  <= phase_n;
      pos    <= pos_n;  div  <= div_n;  tt   <= tt_n;  td   <= td_n;  tbl  <= tbl_n;
      tick   <= tick_n; rs   <= rs_n;   evc  <= evc_n; mk   <= mk_n;  tg   <= tg_n;
      vacc   <= vacc_n; skip <= skip_n; vcnt <= vcnt_n; midx <= midx_n; pst <= pst_n;
      held   <= held_n; active <= active_n; notes <= notes_n; hidx <= hidx_n;
      hbad   <= hbad_n; take <= take_n;
      tempo  <= tempo_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      if (wr_en) mem[held] <= tick;
      start_q <= mem[held];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      snap_note  <= held;
      snap_count <= 10'(notes_n);
      snap_tick  <= tick;
      snap_tempo <= tempo;
      snap_tpq   <= (div != '0) ? div :
                    ((fallback_ticks_per_quarter != '0) ? fallback_ticks_per_quarter : 16'd1);
      end_count  <= 10'(notes_n);
      end_status <= (pos_n < PW'(14)) ? ST_SHORT : pst_n;
    end
  end

  // Duration: (ticks * tempo) in two 16-bit halves, then a bit-serial divide by tpq*1000.
  logic [31:0]      ticks;
  logic [39:0]      pprod;
  logic [DIV_W:0]   trial;
  assign ticks = snap_tick - start_q;
  assign pprod = {24'b0, (cmd.mul0 ? ticks[15:0] : ticks[31:16])} * {16'b0, snap_tempo};
  assign trial = {rem, q[PROD_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.mul0) begin
      q   <= {16'b0, pprod};
      dvs <= DIV_W'(snap_tpq) * DIV_W'(MS_DIVISOR);
    end else if (cmd.mul1) begin
      q   <= q + {pprod, 16'b0};
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div) begin
      cnt <= cnt + 1'b1;
      if (trial >= {1'b0, dvs}) begin
        rem <= DIV_W'(trial - {1'b0, dvs});
        q   <= {q[PROD_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIV_W-1:0];
        q   <= {q[PROD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.load_note || cmd.load_end) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_note) begin
      out_word <= '{result_kind: KIND_NOTE, note: snap_note, duration_ms: q[31:0],
                    note_count: snap_count, status: ST_OK};
    end else if (cmd.load_end) begin
      out_word <= '{result_kind: KIND_END, note: 7'd0, duration_ms: 32'd0,
                    note_count: end_count, status: end_status};
    end
  end

  assign stat.emit     = emit;
  assign stat.div_done = (cnt == CW'(PROD_W - 1));
  assign stat.out_free = !out_valid || out_ready;

endmodule

### src/midi_file_note_extractor_core.sv
// ---------------------------------------------------------------------------
// midi_file_note_extractor_core
// Standard MIDI file parser that reports finished notes and an end summary.
// ---------------------------------------------------------------------------
// A byte that ends no note and is not the last of a file is handled in S_IDLE
// alone, so the block accepts a word every cycle while parsing such bytes. A
// byte that ends an active note below MAX_NOTES runs S_MUL0 and S_MUL1 for the
// 32x24 tick-by-tempo product, done as two 16-bit partial products, and S_DIV
// for the bit-serial divide by ticks-per-quarter times 1000, then S_NOTE to
// hand the result to the output register. The end summary follows in S_END.
// The output register lets the next byte in while a result waits to be taken.
`timescale 1ns / 1ps

module midi_file_note_extractor_core
  import mfne_pkg::*;
#(
  parameter int MAX_NOTES      = MAX_NOTES_DEF,
  parameter int MAX_FILE_BYTES = MAX_FILE_BYTES_DEF
)(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [23:0] default_tempo_us;
  logic [15:0] fallback_ticks_per_quarter;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_tempo_us           <= DEFAULT_TEMPO_RST;
      fallback_ticks_per_quarter <= FALLBACK_TPQ_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_DEFAULT_TEMPO: default_tempo_us           <= pwdata[23:0];
        REG_FALLBACK_TPQ:  fallback_ticks_per_quarter <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DEFAULT_TEMPO: prdata = {8'b0, default_tempo_us};
      REG_FALLBACK_TPQ:  prdata = {16'b0, fallback_ticks_per_quarter};
      default:           prdata = '0;
    endcase
  end

  mfne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_word.last_byte),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mfne_datapath #(
    .MAX_NOTES      (MAX_NOTES),
    .MAX_FILE_BYTES (MAX_FILE_BYTES)
  ) u_datapath (
    .clk                        (clk),
    .rst                        (rst),
    .in_word                    (in_word),
    .default_tempo_us           (default_tempo_us),
    .fallback_ticks_per_quarter (fallback_ticks_per_quarter),
    .cmd                        (cmd),
    .stat                       (stat),
    .out_word                   (out_word),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready)
  );

endmodule
